>>> src/lcp_pkg.sv
`default_nettype none

package lcp_pkg;

   localparam int CAPACITY_DEF  = 64;
   localparam int KEY_WIDTH_DEF = 32;

   // fixed widths of the channel fields
   localparam int OP_W     = 3;
   localparam int IN_KEY_W = 32;
   localparam int OCC_W    = 7;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_TOUCH  = 3'd1,
      OP_DELETE = 3'd2,
      OP_LOOKUP = 3'd3,
      OP_SETPIN = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_RESP
   } state_type;

   // rewrite applied during the update sweep
   typedef enum logic [2:0] {
      UPD_FILL,
      UPD_EVICT,
      UPD_TOUCH,
      UPD_DELETE,
      UPD_PIN
   } upd_type;

endpackage

`default_nettype wire

>>> src/lcp_if.sv
`default_nettype none

interface lcp_req_if import lcp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OP_W-1:0]     op;
   logic [IN_KEY_W-1:0] key;
   logic                pin;

   modport source (output valid, output op, output key, output pin, input ready);
   modport sink   (input valid, input op, input key, input pin, output ready);
endinterface

interface lcp_rsp_if import lcp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                hit;
   logic                evicted_valid;
   logic [IN_KEY_W-1:0] evicted_key;
   logic                full_error;
   logic [OCC_W-1:0]    occupancy;

   modport source (output valid, output hit, output evicted_valid, output evicted_key,
                   output full_error, output occupancy, input ready);
   modport sink   (input valid, input hit, input evicted_valid, input evicted_key,
                   input full_error, input occupancy, output ready);
endinterface

`default_nettype wire

>>> src/lru_cache_with_pinned_entries_top.sv
// Fully associative table of up to CAPACITY keys held in recency order, with
// pin bits that shield entries from eviction.
//
// Request channel (req_bus): one word per operation - op, key and pin.
// Codes: insert, touch to front, delete, lookup, set pin bit. Response
// channel (rsp_bus): exactly one word per request - hit, eviction flag and
// key, full error and the occupancy after the operation.
//
// Timing: one request at a time. The sequencer sweeps the entry memory once
// to find the key, a free slot and the eviction victim, then decides, and
// sweeps again to rewrite entries when the operation changes the table. The
// entry memory, with separate read and write addresses, reads one entry and
// writes one per cycle.
//
// Reset (synchronous) empties the table at once through per-entry valid bits;
// the entry memory itself needs no clearing. A stalled response word is held
// stable until taken, and no request is taken meanwhile.
`default_nettype none

module lru_cache_with_pinned_entries_top
   import lcp_pkg::*;
#(
   parameter int CAPACITY  = CAPACITY_DEF,
   parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   lcp_req_if.sink     req_bus,
   lcp_rsp_if.source   rsp_bus
);

   localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int RANK_W = IDX_W;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam logic [IDX_W:0] SWEEP_END = (IDX_W + 1)'(CAPACITY);

   typedef struct packed {
      logic                 pinned;
      logic [RANK_W-1:0]    rank;
      logic [KEY_WIDTH-1:0] key;
   } entry_type;

   // entry memory: key, pin bit and recency rank of each slot
   entry_type entry_mem [CAPACITY];
   entry_type rd_word_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_wa;
   logic [IDX_W-1:0] mem_ra;
   entry_type        mem_wd;

   state_type state_ff, state_in;
   logic [IDX_W:0]   cnt_ff, cnt_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;

   logic [OP_W-1:0]      op_ff, op_in;
   logic [KEY_WIDTH-1:0] key_ff, key_in;
   logic                 pin_ff, pin_in;

   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     s_ff, s_in;
   logic [RANK_W-1:0]    srank_ff, srank_in;
   logic                 free_ff, free_in;
   logic [IDX_W-1:0]     f_ff, f_in;
   logic                 vfound_ff, vfound_in;
   logic [IDX_W-1:0]     vic_ff, vic_in;
   logic [RANK_W-1:0]    vrank_ff, vrank_in;
   logic [KEY_WIDTH-1:0] vkey_ff, vkey_in;

   upd_type              upd_ff, upd_in;
   logic [RANK_W-1:0]    passed_ff, passed_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CAPACITY-1:0]  valid_ff, valid_in;

   logic                 hit_ff, hit_in;
   logic                 evv_ff, evv_in;
   logic [IN_KEY_W-1:0]  evkey_ff, evkey_in;
   logic                 full_ff, full_in;

   // memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      rd_word_ff <= entry_mem[mem_ra];
   end

   always_comb begin
      logic cur_valid;
      entry_type w;
      cur_valid = valid_ff[pidx_ff];
      w         = rd_word_ff;

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pend_in   = 1'b0;
      pidx_in   = cnt_ff[IDX_W-1:0];
      op_in     = op_ff;
      key_in    = key_ff;
      pin_in    = pin_ff;
      found_in  = found_ff;
      s_in      = s_ff;
      srank_in  = srank_ff;
      free_in   = free_ff;
      f_in      = f_ff;
      vfound_in = vfound_ff;
      vic_in    = vic_ff;
      vrank_in  = vrank_ff;
      vkey_in   = vkey_ff;
      upd_in    = upd_ff;
      passed_in = passed_ff;
      count_in  = count_ff;
      valid_in  = valid_ff;
      hit_in    = hit_ff;
      evv_in    = evv_ff;
      evkey_in  = evkey_ff;
      full_in   = full_ff;
      mem_we    = 1'b0;
      mem_wa    = pidx_ff;
      mem_wd    = rd_word_ff;
      mem_ra    = cnt_ff[IDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               op_in     = req_bus.op;
               key_in    = KEY_WIDTH'(req_bus.key);
               pin_in    = req_bus.pin;
               found_in  = 1'b0;
               free_in   = 1'b0;
               vfound_in = 1'b0;
               cnt_in    = '0;
               state_in  = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // issue one read a cycle, judge the word read the cycle before
            if (cnt_ff < SWEEP_END) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               state_in = ST_DECIDE;
            end
            if (pend_ff) begin
               if (cur_valid && w.key == key_ff) begin
                  found_in = 1'b1;
                  s_in     = pidx_ff;
                  srank_in = w.rank;
               end
               if (!cur_valid && !free_ff) begin
                  free_in = 1'b1;
                  f_in    = pidx_ff;
               end
               if (cur_valid && !w.pinned && (!vfound_ff || w.rank > vrank_ff)) begin
                  vfound_in = 1'b1;
                  vic_in    = pidx_ff;
                  vrank_in  = w.rank;
                  vkey_in   = w.key;
               end
            end
         end

         ST_DECIDE: begin
            hit_in   = found_ff;
            evv_in   = 1'b0;
            evkey_in = '0;
            full_in  = 1'b0;
            cnt_in   = '0;
            state_in = ST_RESP;
            if (op_ff == OP_INSERT && !found_ff) begin
               if (free_ff) begin
                  upd_in          = UPD_FILL;
                  valid_in[f_ff]  = 1'b1;
                  count_in        = count_ff + 1'b1;
                  state_in        = ST_UPDATE;
               end else if (vfound_ff) begin
                  upd_in    = UPD_EVICT;
                  evv_in    = 1'b1;
                  evkey_in  = IN_KEY_W'(vkey_ff);
                  passed_in = RANK_W'(count_ff - CNT_W'(1) - CNT_W'(vrank_ff));
                  state_in  = ST_UPDATE;
               end else begin
                  // every entry pinned: refuse
                  full_in = 1'b1;
               end
            end else if (op_ff == OP_TOUCH && found_ff) begin
               upd_in   = UPD_TOUCH;
               state_in = ST_UPDATE;
            end else if (op_ff == OP_DELETE && found_ff) begin
               upd_in         = UPD_DELETE;
               valid_in[s_ff] = 1'b0;
               count_in       = count_ff - 1'b1;
               state_in       = ST_UPDATE;
            end else if (op_ff == OP_SETPIN && found_ff) begin
               upd_in   = UPD_PIN;
               state_in = ST_UPDATE;
            end
         end

         ST_UPDATE: begin
            if (cnt_ff < SWEEP_END) begin
               pend_in = 1'b1;
               cnt_in  = cnt_ff + 1'b1;
            end else begin
               state_in = ST_RESP;
            end
            if (pend_ff) begin
               case (upd_ff)
                  UPD_FILL: begin
                     if (pidx_ff == f_ff) begin
                        mem_we = 1'b1;
                        mem_wd = '{pinned: pin_ff, rank: '0, key: key_ff};
                     end else if (cur_valid) begin
                        mem_we      = 1'b1;
                        mem_wd.rank = w.rank + 1'b1;
                     end
                  end
                  UPD_EVICT: begin
                     if (pidx_ff == vic_ff) begin
                        mem_we = 1'b1;
                        mem_wd = '{pinned: pin_ff, rank: passed_ff, key: key_ff};
                     end else if (cur_valid) begin
                        mem_we = 1'b1;
                        // older than the victim: move to the front; newer: behind the passed-over
                        if (w.rank > vrank_ff) begin
                           mem_wd.rank = w.rank - vrank_ff - 1'b1;
                        end else begin
                           mem_wd.rank = w.rank + passed_ff + 1'b1;
                        end
                     end
                  end
                  UPD_TOUCH: begin
                     if (pidx_ff == s_ff) begin
                        mem_we      = 1'b1;
                        mem_wd.rank = '0;
                     end else if (cur_valid && w.rank < srank_ff) begin
                        mem_we      = 1'b1;
                        mem_wd.rank = w.rank + 1'b1;
                     end
                  end
                  UPD_DELETE: begin
                     if (cur_valid && w.rank > srank_ff) begin
                        mem_we      = 1'b1;
                        mem_wd.rank = w.rank - 1'b1;
                     end
                  end
                  UPD_PIN: begin
                     if (pidx_ff == s_ff) begin
                        mem_we        = 1'b1;
                        mem_wd.pinned = pin_ff;
                     end
                  end
                  default: begin
                     mem_we = 1'b0;
                  end
               endcase
            end
         end

         ST_RESP: begin
            // hold the response word until taken
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         count_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      pidx_ff   <= pidx_in;
      op_ff     <= op_in;
      key_ff    <= key_in;
      pin_ff    <= pin_in;
      found_ff  <= found_in;
      s_ff      <= s_in;
      srank_ff  <= srank_in;
      free_ff   <= free_in;
      f_ff      <= f_in;
      vfound_ff <= vfound_in;
      vic_ff    <= vic_in;
      vrank_ff  <= vrank_in;
      vkey_ff   <= vkey_in;
      upd_ff    <= upd_in;
      passed_ff <= passed_in;
      hit_ff    <= hit_in;
      evv_ff    <= evv_in;
      evkey_ff  <= evkey_in;
      full_ff   <= full_in;
   end

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = (state_ff == ST_RESP);
   assign rsp_bus.hit           = hit_ff;
   assign rsp_bus.evicted_valid = evv_ff;
   assign rsp_bus.evicted_key   = evkey_ff;
   assign rsp_bus.full_error    = full_ff;
   assign rsp_bus.occupancy     = OCC_W'(count_ff);

   // occupancy tracks the valid bits whenever the table is at rest
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_RESP) |-> ($countones(valid_ff) == count_ff))
      else $error("occupancy count out of step with valid bits");

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("occupancy beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> !(rsp_bus.evicted_valid && rsp_bus.full_error))
      else $error("eviction and full error in one response");

   // a request is taken only once the previous response has gone
   assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !rsp_bus.valid)
      else $error("response shown straight after accepting a request");

endmodule

`default_nettype wire

>>> dv/testbench.sv
`default_nettype none

module testbench
   import lcp_pkg::*;
();

   localparam int CAP      = CAPACITY_DEF;
   localparam int MAX_LAT  = 2 * CAP + 8;   // longest request, with some slack
   localparam int POOL_LEN = 128;
   localparam int OWED_LEN = 16;

   // one response word as the block should present it
   typedef struct packed {
      logic                hit;
      logic                evicted_valid;
      logic [IN_KEY_W-1:0] evicted_key;
      logic                full_error;
      logic [OCC_W-1:0]    occupancy;
   } lru_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lcp_req_if req_bus ();
   lcp_rsp_if rsp_bus ();

   lru_cache_with_pinned_entries_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the table: keys, valid and pin bits, recency rank
   // (0 = most recent) and the entry count.
   logic [IN_KEY_W-1:0] tbl_key    [CAP];
   logic                tbl_valid  [CAP];
   logic                tbl_pinned [CAP];
   int                  tbl_rank   [CAP];
   int                  tbl_count;

   // responses owed by the block, oldest first: written at owed_wr by the
   // sender, read at owed_rd by the checker
   lru_rsp_type         owed_rsp [OWED_LEN];
   int                  owed_wr = 0;
   int                  owed_rd = 0;
   logic [IN_KEY_W-1:0] key_pool [POOL_LEN];
   int                  fault_count = 0;
   bit                  calm;              // set: neither side idles
   bit                  offering;          // mirrors req_bus.valid as last driven

   // Apply one operation to the shadow table and return the response word
   // that the block must produce for it.
   function automatic lru_rsp_type shadow_apply(logic [OP_W-1:0] op,
                                                logic [IN_KEY_W-1:0] key, logic pin);
      lru_rsp_type r;
      int          i, slot, spare, victim, vr, passed;
      r      = '0;
      slot   = -1;
      spare  = -1;
      victim = -1;
      for (i = 0; i < CAP; i++) begin
         if (tbl_valid[i] && tbl_key[i] == key && slot < 0) slot = i;
         if (!tbl_valid[i] && spare < 0) spare = i;
      end
      r.hit = (slot >= 0);
      if (op == OP_INSERT && slot < 0) begin
         if (spare >= 0) begin
            // room left: everyone ages by one, newcomer goes to the front
            for (i = 0; i < CAP; i++)
               if (tbl_valid[i]) tbl_rank[i]++;
            tbl_key[spare]    = key;
            tbl_valid[spare]  = 1'b1;
            tbl_pinned[spare] = pin;
            tbl_rank[spare]   = 0;
            tbl_count++;
         end else begin
            for (i = 0; i < CAP; i++)
               if (tbl_valid[i] && !tbl_pinned[i] &&
                   (victim < 0 || tbl_rank[i] > tbl_rank[victim]))
                  victim = i;
            if (victim < 0) begin
               r.full_error = 1'b1;
            end else begin
               // pinned entries older than the victim rotate to the front,
               // ahead of the newcomer, keeping their order
               vr              = tbl_rank[victim];
               passed          = tbl_count - 1 - vr;
               r.evicted_valid = 1'b1;
               r.evicted_key   = tbl_key[victim];
               for (i = 0; i < CAP; i++) begin
                  if (tbl_valid[i] && i != victim) begin
                     if (tbl_rank[i] > vr) tbl_rank[i] -= vr + 1;
                     else tbl_rank[i] += passed + 1;
                  end
               end
               tbl_key[victim]    = key;
               tbl_pinned[victim] = pin;
               tbl_rank[victim]   = passed;
            end
         end
      end else if (op == OP_TOUCH && slot >= 0) begin
         vr = tbl_rank[slot];
         for (i = 0; i < CAP; i++)
            if (tbl_valid[i] && tbl_rank[i] < vr) tbl_rank[i]++;
         tbl_rank[slot] = 0;
      end else if (op == OP_DELETE && slot >= 0) begin
         vr               = tbl_rank[slot];
         tbl_valid[slot]  = 1'b0;
         tbl_pinned[slot] = 1'b0;
         tbl_rank[slot]   = 0;
         for (i = 0; i < CAP; i++)
            if (tbl_valid[i] && tbl_rank[i] > vr) tbl_rank[i]--;
         if (tbl_count > 0) tbl_count--;
      end else if (op == OP_SETPIN && slot >= 0) begin
         tbl_pinned[slot] = pin;
      end
      r.occupancy = tbl_count[OCC_W-1:0];
      return r;
   endfunction

   function automatic bit shadow_holds(logic [IN_KEY_W-1:0] key);
      int i;
      for (i = 0; i < CAP; i++)
         if (tbl_valid[i] && tbl_key[i] == key) return 1'b1;
      return 1'b0;
   endfunction

   // a key not currently in the table
   function automatic logic [IN_KEY_W-1:0] fresh_key();
      logic [IN_KEY_W-1:0] k;
      k = $urandom;
      while (shadow_holds(k)) k = $urandom;
      return k;
   endfunction

   // a key currently in the table, picked at random; any key if empty
   function automatic logic [IN_KEY_W-1:0] resident_key();
      int start, i;
      start = $urandom_range(0, CAP - 1);
      for (i = 0; i < CAP; i++)
         if (tbl_valid[(start + i) % CAP]) return tbl_key[(start + i) % CAP];
      return $urandom;
   endfunction

   // Offer one request word and hold it until taken. Valid stays high on
   // return so that a following word can go out back to back; anything
   // that waits without sending must drop it first.
   task automatic issue_op(logic [OP_W-1:0] op, logic [IN_KEY_W-1:0] key, logic pin);
      int gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < 8) gap = $urandom_range(1, MAX_LAT);
      if (gap > 0) begin
         if (offering) req_bus.valid <= 1'b0;
         offering = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.key   <= key;
      req_bus.pin   <= pin;
      offering = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      owed_rsp[owed_wr % OWED_LEN] = shadow_apply(op, key, pin);
      owed_wr++;
   endtask

   // drop valid and hold until every owed response has come back
   task automatic await_drain();
      if (offering) req_bus.valid <= 1'b0;
      offering = 1'b0;
      while (owed_wr != owed_rd) @(posedge clock);
   endtask

   task automatic check_field(string field, logic [IN_KEY_W-1:0] want,
                              logic [IN_KEY_W-1:0] got);
      if (got !== want) begin
         fault_count++;
         if (fault_count <= 10)
            $display("rsp mismatch on %s: expected %h, got %h", field, want, got);
      end
   endtask

   // Response side: compare each taken word with the oldest owed one, then
   // pick ready for the next cycle (stall with a chance of 8 in a hundred unless calm).
   always @(posedge clock) begin : rsp_check
      lru_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (owed_wr == owed_rd) begin
            fault_count++;
            if (fault_count <= 10)
               $display("rsp word with nothing owed: occupancy %0d", rsp_bus.occupancy);
         end else begin
            want = owed_rsp[owed_rd % OWED_LEN];
            owed_rd++;
            check_field("hit", IN_KEY_W'(want.hit), IN_KEY_W'(rsp_bus.hit));
            check_field("evicted_valid", IN_KEY_W'(want.evicted_valid),
                        IN_KEY_W'(rsp_bus.evicted_valid));
            check_field("evicted_key", want.evicted_key, rsp_bus.evicted_key);
            check_field("full_error", IN_KEY_W'(want.full_error),
                        IN_KEY_W'(rsp_bus.full_error));
            check_field("occupancy", IN_KEY_W'(want.occupancy),
                        IN_KEY_W'(rsp_bus.occupancy));
         end
      end
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 8);
   end

   // Empty table first, then each operation on absent and present keys,
   // the extreme keys, a repeated insert and the unused op codes.
   task automatic test_basic_ops();
      logic [OP_W-1:0] code;
      issue_op(OP_LOOKUP, '0, 1'b0);
      issue_op(OP_TOUCH, '1, 1'b0);
      issue_op(OP_DELETE, '0, 1'b1);
      issue_op(OP_SETPIN, '0, 1'b1);
      issue_op(OP_W'(OP_SETPIN + 1), '1, 1'b1);
      issue_op(OP_INSERT, '0, 1'b0);
      issue_op(OP_INSERT, '1, 1'b1);
      issue_op(OP_INSERT, 32'h8000_0001, 1'b0);
      issue_op(OP_INSERT, '0, 1'b1);            // already present: hit only
      issue_op(OP_LOOKUP, '1, 1'b0);
      issue_op(OP_TOUCH, '0, 1'b0);
      issue_op(OP_SETPIN, '1, 1'b0);
      issue_op(OP_SETPIN, '0, 1'b1);
      for (code = OP_W'(OP_SETPIN + 1); code != '0; code++)
         issue_op(code, '0, code[0]);
      issue_op(OP_DELETE, '1, 1'b0);
      issue_op(OP_DELETE, '1, 1'b0);            // second delete misses
      issue_op(OP_LOOKUP, '1, 1'b1);
   endtask

   // Fill the table, then keep inserting so that evictions pass over
   // pinned entries; touch residents in between to stir the order.
   task automatic test_eviction_order();
      int n;
      while (tbl_count < CAP)
         issue_op(OP_INSERT, fresh_key(), $urandom_range(0, 3) == 0);
      for (n = 0; n < 24; n++) begin
         if (n % 3 == 1) issue_op(OP_TOUCH, resident_key(), 1'b0);
         issue_op(OP_INSERT, fresh_key(), $urandom_range(0, 3) == 0);
      end
   endtask

   // Empty the table, fill it with pinned entries only, and check that an
   // insert is refused until one entry is unpinned.
   task automatic test_all_pinned();
      logic [IN_KEY_W-1:0] doomed [CAP];
      int                  n_doomed, i;
      n_doomed = 0;
      for (i = 0; i < CAP; i++) begin
         if (tbl_valid[i]) begin
            doomed[n_doomed] = tbl_key[i];
            n_doomed++;
         end
      end
      for (i = 0; i < n_doomed; i++) issue_op(OP_DELETE, doomed[i], 1'b0);
      while (tbl_count < CAP) issue_op(OP_INSERT, fresh_key(), 1'b1);
      issue_op(OP_INSERT, fresh_key(), 1'b0);   // refused
      issue_op(OP_INSERT, resident_key(), 1'b0); // present key: hit, no error
      issue_op(OP_SETPIN, resident_key(), 1'b0);
      issue_op(OP_INSERT, fresh_key(), 1'b0);   // evicts the one unpinned entry
      issue_op(OP_INSERT, fresh_key(), 1'b1);   // evicts the previous newcomer
      issue_op(OP_INSERT, fresh_key(), 1'b0);   // all pinned again: refused
   endtask

   // Random operations, mostly on resident or pooled keys so that hits,
   // evictions and refusals keep coming; a few wholly random keys as noise.
   task automatic test_random_mix(int count, int pin_pct);
      int                  n, roll;
      logic [OP_W-1:0]     op;
      logic [IN_KEY_W-1:0] key;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 35)      op = OP_INSERT;
         else if (roll < 50) op = OP_TOUCH;
         else if (roll < 60) op = OP_DELETE;
         else if (roll < 75) op = OP_LOOKUP;
         else if (roll < 95) op = OP_SETPIN;
         else                op = OP_W'($urandom_range(OP_SETPIN + 1, (1 << OP_W) - 1));
         roll = $urandom_range(0, 99);
         if (roll < 45 && tbl_count > 0) key = resident_key();
         else if (roll < 95)             key = key_pool[$urandom_range(0, POOL_LEN - 1)];
         else                            key = $urandom;
         issue_op(op, key, $urandom_range(0, 99) < pin_pct);
      end
   endtask

   initial begin
      int i;
      calm          = 1'b0;
      offering      = 1'b0;
      tbl_count     = 0;
      req_bus.valid <= 1'b0;
      req_bus.op    <= OP_LOOKUP;
      req_bus.key   <= '0;
      req_bus.pin   <= 1'b0;
      for (i = 0; i < CAP; i++) begin
         tbl_key[i]    = '0;
         tbl_valid[i]  = 1'b0;
         tbl_pinned[i] = 1'b0;
         tbl_rank[i]   = 0;
      end
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (i = 2; i < POOL_LEN; i++) key_pool[i] = $urandom;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_eviction_order();
      test_all_pinned();
      test_random_mix(200, 25);
      await_drain();                 // sender holds off until nothing is owed
      calm = 1'b1;                   // stretch with no idling on either side
      test_random_mix(150, 10);
      calm = 1'b0;
      test_random_mix(150, 85);      // heavy pinning: refusals and rotations

      await_drain();
      repeat (MAX_LAT) @(posedge clock);
      if (fault_count == 0 && owed_wr == owed_rd) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // watchdog, several times the slowest correct run
   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
